/* src/pcga_pkg.sv */
// ---------------------------------------------------------------------------
// pcga_pkg
// Types, register codes and constant tables for the contrast, brightness and
// gamma pixel adjuster.
// ---------------------------------------------------------------------------
package pcga_pkg;

   // pipeline depth of one channel lane, input register to result register
   localparam int LANE_LAT = 49;

   // register reset values
   localparam logic [7:0] CONTRAST_RST   = 8'd100;
   localparam logic [7:0] BRIGHTNESS_RST = 8'd0;
   localparam logic [7:0] GAMMA_RST      = 8'd100;
   localparam logic       LUMA_MODE_RST  = 1'b0;

   // floor(x/100) = (x*5243) >> 19, exact for x below 43690
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   // unity in Q1.32
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   typedef enum logic [1:0] {
      CSR_CONTRAST   = 2'd0,
      CSR_BRIGHTNESS = 2'd1,
      CSR_GAMMA      = 2'd2,
      CSR_LUMA_MODE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
      logic       mask_zero;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rsp_type;

   typedef struct packed {
      logic [7:0] contrast;
      logic [7:0] brightness;
      logic [7:0] gamma;
      logic       luma_mode;
   } cfg_type;

   typedef logic [28:0] lq_tab_type [256];
   typedef logic [6:0]  lr_tab_type [256];
   typedef logic [31:0] root_tab_type [32];

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] vv;
      logic [63:0] res;
      logic [63:0] bitv;
      vv   = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bitv > vv) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (vv >= res + bitv) begin
               vv  = vv - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // log2 of m (1..255), 32 fraction bits, by repeated squaring
   function automatic logic [34:0] log2_q32(input logic [7:0] m);
      logic [63:0] z;
      logic [31:0] frac;
      logic [2:0]  k;
      k    = '0;
      frac = '0;
      for (int i = 1; i < 8; i++) begin
         if ((m >> i) != 0) k = 3'(i);
      end
      z = {56'b0, m} << (30 - int'(k));
      for (int i = 0; i < 32; i++) begin
         z    = (z * z) >> 30;
         frac = {frac[30:0], 1'b0};
         if (z >= 64'h8000_0000) begin
            z       = z >> 1;
            frac[0] = 1'b1;
         end
      end
      return {k, frac};
   endfunction

   // log2(255/p) split as 100*q + r
   function automatic lq_tab_type build_lq();
      lq_tab_type  t;
      logic [34:0] l;
      t[0] = '0;
      for (int p = 1; p < 256; p++) begin
         l    = log2_q32(8'd255) - log2_q32(8'(p));
         t[p] = 29'(l / 100);
      end
      return t;
   endfunction

   function automatic lr_tab_type build_lr();
      lr_tab_type  t;
      logic [34:0] l;
      t[0] = '0;
      for (int p = 1; p < 256; p++) begin
         l    = log2_q32(8'd255) - log2_q32(8'(p));
         t[p] = 7'(l % 100);
      end
      return t;
   endfunction

   // 2^(-2^-(i+1)) in Q0.32
   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  r;
      r    = isqrt64(64'h8000_0000_0000_0000);
      t[0] = r[31:0];
      for (int i = 1; i < 32; i++) begin
         r    = isqrt64({t[i-1], 32'b0});
         t[i] = r[31:0];
      end
      return t;
   endfunction

   localparam lq_tab_type   LQ_TAB   = build_lq();
   localparam lr_tab_type   LR_TAB   = build_lr();
   localparam root_tab_type ROOT_TAB = build_roots();

endpackage

/* src/pcga_lane.sv */
// ---------------------------------------------------------------------------
// pcga_lane
// One channel: x^g through log table and root product chain, then gain,
// offset, ratio scaling and rounding by a restoring divider.
// ---------------------------------------------------------------------------
module pcga_lane (
   input  logic             clock,
   input  logic             en,
   input  pcga_pkg::cfg_type cfg,
   input  logic [7:0]       arg,
   input  logic [7:0]       num,
   input  logic [7:0]       den,
   output logic [7:0]       result
);
   import pcga_pkg::*;

   // stage 0: operands
   logic [7:0] s0_arg_ff, s0_num_ff, s0_den_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s0_arg_ff <= arg;
         s0_num_ff <= num;
         s0_den_ff <= den;
      end
   end

   // stage 1: log table, k = 255*num
   logic [28:0] s1_q_ff;
   logic [6:0]  s1_r_ff;
   logic        s1_zero_ff;
   logic [15:0] s1_k_in, s1_k_ff;
   logic [7:0]  s1_den_ff;
   assign s1_k_in = {s0_num_ff, 8'b0} - {8'b0, s0_num_ff};
   always_ff @(posedge clock) begin
      if (en) begin
         s1_q_ff    <= LQ_TAB[s0_arg_ff];
         s1_r_ff    <= LR_TAB[s0_arg_ff];
         s1_zero_ff <= (s0_arg_ff == 8'd0);
         s1_k_ff    <= s1_k_in;
         s1_den_ff  <= s0_den_ff;
      end
   end

   // stage 2: g*q and g*r + 50
   logic [36:0] s2_gq_in, s2_gq_ff;
   logic [14:0] s2_x_in, s2_x_ff;
   logic        s2_zero_ff;
   logic [15:0] s2_k_ff;
   logic [7:0]  s2_den_ff;
   assign s2_gq_in = 37'(cfg.gamma) * 37'(s1_q_ff);
   assign s2_x_in  = 15'(cfg.gamma) * 15'(s1_r_ff) + 15'd50;
   always_ff @(posedge clock) begin
      if (en) begin
         s2_gq_ff   <= s2_gq_in;
         s2_x_ff    <= s2_x_in;
         s2_zero_ff <= s1_zero_ff;
         s2_k_ff    <= s1_k_ff;
         s2_den_ff  <= s1_den_ff;
      end
   end

   // stage 3: remainder part divided by 100
   logic [27:0] s3_prod;
   logic [7:0]  s3_dq_in, s3_dq_ff;
   logic [36:0] s3_gq_ff;
   logic        s3_zero_ff;
   logic [15:0] s3_k_ff;
   logic [7:0]  s3_den_ff;
   assign s3_prod  = 28'(s2_x_ff) * 28'(DIV100_MUL);
   assign s3_dq_in = 8'(s3_prod >> DIV100_SHIFT);
   always_ff @(posedge clock) begin
      if (en) begin
         s3_dq_ff   <= s3_dq_in;
         s3_gq_ff   <= s2_gq_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_k_ff    <= s2_k_ff;
         s3_den_ff  <= s2_den_ff;
      end
   end

   // stage 4: exponent e = g*log2(255/p)/100, rounded; feeds root chain
   logic [32:0] rt_pw_ff   [0:32];
   logic [31:0] rt_f_ff    [0:32];
   logic [4:0]  rt_n_ff    [0:32];
   logic        rt_zero_ff [0:32];
   logic [15:0] rt_k_ff    [0:32];
   logic [7:0]  rt_den_ff  [0:32];
   logic [36:0] s4_e_in;
   assign s4_e_in = s3_gq_ff + 37'(s3_dq_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         rt_pw_ff[0]   <= ONE_Q32;
         rt_f_ff[0]    <= s4_e_in[31:0];
         rt_n_ff[0]    <= s4_e_in[36:32];
         rt_zero_ff[0] <= s3_zero_ff;
         rt_k_ff[0]    <= s3_k_ff;
         rt_den_ff[0]  <= s3_den_ff;
      end
   end

   // root chain: one fraction bit of e per stage
   for (genvar i = 0; i < 32; i++) begin : g_root
      logic [64:0] prod;
      logic [32:0] pw_in;
      assign prod  = 65'(rt_pw_ff[i]) * 65'(ROOT_TAB[i]);
      assign pw_in = rt_f_ff[i][31-i] ? prod[64:32] : rt_pw_ff[i];
      always_ff @(posedge clock) begin
         if (en) begin
            rt_pw_ff[i+1]   <= pw_in;
            rt_f_ff[i+1]    <= rt_f_ff[i];
            rt_n_ff[i+1]    <= rt_n_ff[i];
            rt_zero_ff[i+1] <= rt_zero_ff[i];
            rt_k_ff[i+1]    <= rt_k_ff[i];
            rt_den_ff[i+1]  <= rt_den_ff[i];
         end
      end
   end

   // P1: integer part of exponent, special cases, c*k, b*k, 50*den, 100*den
   logic [32:0]        p1_pw_in, p1_pw_ff;
   logic [23:0]        p1_ck_in, p1_ck_ff;
   logic signed [24:0] p1_bk_in, p1_bk_ff;
   logic [13:0]        p1_v50_in, p1_v50_ff;
   logic [14:0]        p1_d_in, p1_d_ff;
   always_comb begin
      if (cfg.gamma == 8'd0) begin
         p1_pw_in = ONE_Q32;
      end else if (rt_zero_ff[32]) begin
         p1_pw_in = '0;
      end else begin
         p1_pw_in = rt_pw_ff[32] >> rt_n_ff[32];
      end
   end
   assign p1_ck_in  = 24'(cfg.contrast) * 24'(rt_k_ff[32]);
   assign p1_bk_in  = $signed({{17{cfg.brightness[7]}}, cfg.brightness})
                    * $signed({9'b0, rt_k_ff[32]});
   assign p1_v50_in = 14'(rt_den_ff[32]) * 14'd50;
   assign p1_d_in   = 15'(rt_den_ff[32]) * 15'd100;
   always_ff @(posedge clock) begin
      if (en) begin
         p1_pw_ff  <= p1_pw_in;
         p1_ck_ff  <= p1_ck_in;
         p1_bk_ff  <= p1_bk_in;
         p1_v50_ff <= p1_v50_in;
         p1_d_ff   <= p1_d_in;
      end
   end

   // P2: c*x^g and x^g*c*k
   logic [40:0]        p2_cpw_in, p2_cpw_ff;
   logic [56:0]        p2_prod_in, p2_prod_ff;
   logic signed [24:0] p2_bk_ff;
   logic [13:0]        p2_v50_ff;
   logic [14:0]        p2_d_ff;
   assign p2_cpw_in  = 41'(cfg.contrast) * 41'(p1_pw_ff);
   assign p2_prod_in = 57'(p1_pw_ff) * 57'(p1_ck_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         p2_cpw_ff  <= p2_cpw_in;
         p2_prod_ff <= p2_prod_in;
         p2_bk_ff   <= p1_bk_ff;
         p2_v50_ff  <= p1_v50_ff;
         p2_d_ff    <= p1_d_ff;
      end
   end

   // P3: sign of adjusted value W, dividend M = floor(255*W*num/2^32) + 50*den
   logic [42:0] p3_w;
   logic        p3_wpos_in, p3_wpos_ff;
   logic [26:0] p3_m_in, p3_m_ff;
   logic [14:0] p3_d_ff;
   assign p3_w       = {2'b0, p2_cpw_ff} + {{3{cfg.brightness[7]}}, cfg.brightness, 32'b0};
   assign p3_wpos_in = !p3_w[42] && (p3_w != '0);
   assign p3_m_in    = {2'b0, p2_prod_ff[56:32]} + {{2{p2_bk_ff[24]}}, p2_bk_ff}
                     + {13'b0, p2_v50_ff};
   always_ff @(posedge clock) begin
      if (en) begin
         p3_wpos_ff <= p3_wpos_in;
         p3_m_ff    <= p3_m_in;
         p3_d_ff    <= p2_d_ff;
      end
   end

   // divider: index 0 holds range check, then one quotient bit per stage
   logic [22:0] dv_r_ff    [0:8];
   logic [7:0]  dv_q_ff    [0:8];
   logic [14:0] dv_d_ff    [0:8];
   logic        dv_zero_ff [0:8];
   logic        dv_sat_ff  [0:8];
   logic        dv_zero_in, dv_sat_in;
   assign dv_zero_in = !p3_wpos_ff || p3_m_ff[26];
   assign dv_sat_in  = p3_m_ff[25:0] >= {3'b0, p3_d_ff, 8'b0};
   always_ff @(posedge clock) begin
      if (en) begin
         dv_r_ff[0]    <= p3_m_ff[22:0];
         dv_q_ff[0]    <= '0;
         dv_d_ff[0]    <= p3_d_ff;
         dv_zero_ff[0] <= dv_zero_in;
         dv_sat_ff[0]  <= dv_sat_in;
      end
   end

   for (genvar j = 0; j < 8; j++) begin : g_div
      logic [22:0] trial;
      logic        take;
      assign trial = {8'b0, dv_d_ff[j]} << (7 - j);
      assign take  = dv_r_ff[j] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            dv_r_ff[j+1]    <= take ? dv_r_ff[j] - trial : dv_r_ff[j];
            dv_q_ff[j+1]    <= {dv_q_ff[j][6:0], take};
            dv_d_ff[j+1]    <= dv_d_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_sat_ff[j+1]  <= dv_sat_ff[j];
         end
      end
   end

   // saturate
   always_comb begin
      if (dv_zero_ff[8]) begin
         result = '0;
      end else if (dv_sat_ff[8]) begin
         result = 8'hFF;
      end else begin
         result = dv_q_ff[8];
      end
   end

endmodule

/* src/pixel_contrast_gamma_adjust_top.sv */
// Throughput: one pixel per cycle; a stalled result freezes the whole pipeline.
// Depth is set by the 32-stage root product chain and the 8-stage divider.
// Reset clears all valid bits and loads contrast 100, brightness 0,
// gamma 100 and per-channel mode.
// ---------------------------------------------------------------------------
// pixel_contrast_gamma_adjust_top
// Contrast, brightness and gamma adjustment of one BGR pixel per clock while the
// output is not held, per channel or on the HSV value, with mask pass-through.
// ---------------------------------------------------------------------------
module pixel_contrast_gamma_adjust_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcga_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcga_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import pcga_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contrast   <= CONTRAST_RST;
         cfg_ff.brightness <= BRIGHTNESS_RST;
         cfg_ff.gamma      <= GAMMA_RST;
         cfg_ff.luma_mode  <= LUMA_MODE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONTRAST:   cfg_ff.contrast   <= csr_wdata;
            CSR_BRIGHTNESS: cfg_ff.brightness <= csr_wdata;
            CSR_GAMMA:      cfg_ff.gamma      <= csr_wdata;
            CSR_LUMA_MODE:  cfg_ff.luma_mode  <= csr_wdata[0];
            default:        cfg_ff.luma_mode  <= cfg_ff.luma_mode;
         endcase
      end
   end

   // pipeline advance: whole pipe moves unless the result is held
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // lane operands: value max in luma mode, ratio num/den per channel
   logic [7:0] px [3];
   logic [7:0] vmax;
   logic [7:0] ln_arg [3];
   logic [7:0] ln_num [3];
   logic [7:0] ln_den [3];
   assign px[0] = req_data.in_blue;
   assign px[1] = req_data.in_green;
   assign px[2] = req_data.in_red;
   always_comb begin
      vmax = px[0];
      if (px[1] > vmax) vmax = px[1];
      if (px[2] > vmax) vmax = px[2];
      for (int k = 0; k < 3; k++) begin
         if (!cfg_ff.luma_mode) begin
            ln_arg[k] = px[k];
            ln_num[k] = 8'd1;
            ln_den[k] = 8'd1;
         end else if (vmax == 8'd0) begin
            ln_arg[k] = vmax;
            ln_num[k] = 8'd1;
            ln_den[k] = 8'd1;
         end else begin
            ln_arg[k] = vmax;
            ln_num[k] = px[k];
            ln_den[k] = vmax;
         end
      end
   end

   // channel lanes
   logic [7:0] ln_res [3];
   for (genvar k = 0; k < 3; k++) begin : g_lane
      pcga_lane u_lane (
         .clock  (clock),
         .en     (en),
         .cfg    (cfg_ff),
         .arg    (ln_arg[k]),
         .num    (ln_num[k]),
         .den    (ln_den[k]),
         .result (ln_res[k])
      );
   end

   // valid bits and source pixel travel alongside the lanes
   logic [LANE_LAT-1:0] vld_ff;
   req_type             pix_ff [LANE_LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LANE_LAT-2:0], req_valid};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff[0] <= req_data;
         for (int s = 1; s < LANE_LAT; s++) pix_ff[s] <= pix_ff[s-1];
      end
   end

   // result: masked pixels pass unchanged
   req_type last_pix;
   assign last_pix  = pix_ff[LANE_LAT-1];
   assign rsp_valid = vld_ff[LANE_LAT-1];
   always_comb begin
      if (last_pix.mask_zero) begin
         rsp_data.out_blue  = last_pix.in_blue;
         rsp_data.out_green = last_pix.in_green;
         rsp_data.out_red   = last_pix.in_red;
      end else begin
         rsp_data.out_blue  = ln_res[0];
         rsp_data.out_green = ln_res[1];
         rsp_data.out_red   = ln_res[2];
      end
   end

`ifndef SYNTH
   // a transfer enters the valid chain
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted pixel missing from stage 0");

   // a held result freezes every stage; checked on the valid chain
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff))
      else $error("pipeline moved during output stall");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

/* tb/tb_pixel_contrast_gamma_adjust_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pixel_contrast_gamma_adjust_top
// Streams BGR pixels through the contrast, brightness and gamma adjuster
// under several register settings and checks every output pixel against a
// fixed-point predictor of the adjustment, with random idling on both sides
// and one long output stall that fills the pipeline.
// ---------------------------------------------------------------------------
module tb_pixel_contrast_gamma_adjust_top;
   import pcga_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   // predictor copy of the registers
   logic [7:0]  cur_contrast;
   logic [7:0]  cur_brightness;
   logic [7:0]  cur_gamma;
   logic        cur_luma;
   logic [63:0] half_root [32];

   rsp_type expected_pixels [$];
   int      error_count;
   int      stall_hold;
   bit      quiet;
   int      idle_cycles;

   pixel_contrast_gamma_adjust_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] acc;
      logic [63:0] b;
      rem = v;
      acc = '0;
      b   = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= acc + b) begin
            rem = rem - (acc + b);
            acc = (acc >> 1) + b;
         end else begin
            acc = acc >> 1;
         end
         b = b >> 2;
      end
      return acc;
   endfunction

   // log2 of m, 32 fraction bits
   function automatic logic [63:0] log2_fix(input int unsigned m);
      int unsigned k;
      logic [63:0] z;
      logic [63:0] frac;
      k    = 0;
      frac = '0;
      while (k < 7 && (m >> (k + 1)) != 0) k++;
      z = 64'(m) << (30 - k);
      for (int i = 0; i < 32; i++) begin
         z    = (z * z) >> 30;
         frac = frac << 1;
         if (z >= (64'd1 << 31)) begin
            z    = z >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(k) << 32) | frac;
   endfunction

   // (p/255)^(g/100), unity = 2^32
   function automatic logic [63:0] power_fix(input logic [7:0] p, input logic [7:0] g);
      logic [63:0] l;
      logic [63:0] e;
      logic [63:0] pw;
      logic [63:0] n;
      if (g == 0) return 64'd1 << 32;
      if (p == 0) return 64'd0;
      l  = log2_fix(255) - log2_fix(p);
      e  = (64'(g) * l + 64'd50) / 64'd100;
      n  = e >> 32;
      pw = 64'd1 << 32;
      for (int i = 0; i < 32; i++) begin
         if (e[31 - i]) pw = (pw * half_root[i]) >> 32;
      end
      if (n >= 63) return 64'd0;
      return pw >> n;
   endfunction

   function automatic longint gain_offset(input logic [7:0] p);
      return longint'(cur_contrast) * longint'(power_fix(p, cur_gamma))
           + longint'($signed(cur_brightness)) * (longint'(1) << 32);
   endfunction

   function automatic logic [7:0] round_sat(input longint w, input longint num,
                                            input longint den);
      longint t;
      longint d;
      longint r;
      t = w * 255 * num;
      d = 100 * (longint'(1) << 32) * den;
      if (t <= 0) return 8'd0;
      r = (t + d / 2) / d;
      return (r > 255) ? 8'd255 : 8'(r);
   endfunction

   function automatic rsp_type predict_pixel(input req_type px);
      rsp_type o;
      logic [7:0] v;
      longint w;
      if (px.mask_zero) begin
         o.out_blue  = px.in_blue;
         o.out_green = px.in_green;
         o.out_red   = px.in_red;
      end else if (cur_luma) begin
         v = px.in_blue;
         if (px.in_green > v) v = px.in_green;
         if (px.in_red > v) v = px.in_red;
         w = gain_offset(v);
         if (v == 0) begin
            o.out_blue  = round_sat(w, 1, 1);
            o.out_green = o.out_blue;
            o.out_red   = o.out_blue;
         end else begin
            o.out_blue  = round_sat(w, px.in_blue, v);
            o.out_green = round_sat(w, px.in_green, v);
            o.out_red   = round_sat(w, px.in_red, v);
         end
      end else begin
         o.out_blue  = round_sat(gain_offset(px.in_blue), 1, 1);
         o.out_green = round_sat(gain_offset(px.in_green), 1, 1);
         o.out_red   = round_sat(gain_offset(px.in_red), 1, 1);
      end
      return o;
   endfunction

   // ---------------- transfer helpers ----------------

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // one input transfer; the prediction is taken at acceptance
   task automatic send_pixel(input req_type px);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(predict_pixel(px));
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_sender();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write enable stays up across back-to-back writes; the caller drops it
   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CONTRAST:   cur_contrast   = val;
         CSR_BRIGHTNESS: cur_brightness = val;
         CSR_GAMMA:      cur_gamma      = val;
         CSR_LUMA_MODE:  cur_luma       = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] c, input logic [7:0] b,
                             input logic [7:0] g, input logic luma);
      wait_drained();
      write_csr(CSR_CONTRAST, c);
      write_csr(CSR_BRIGHTNESS, b);
      write_csr(CSR_GAMMA, g);
      write_csr(CSR_LUMA_MODE, {7'd0, luma});
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type make_pixel(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r, input logic m);
      req_type px;
      px.in_blue   = b;
      px.in_green  = g;
      px.in_red    = r;
      px.mask_zero = m;
      return px;
   endfunction

   function automatic req_type random_pixel();
      return make_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                        $urandom_range(0, 7) == 0);
   endfunction

   // ---------------- tests ----------------

   // reset values, extremes of the channels, mask pass-through
   task automatic test_reset_defaults();
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd1, 8'd128, 8'd254, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd77, 1'b1));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
   endtask

   // zero gamma, zero source, gain and offset extremes per channel
   task automatic test_per_channel_extremes();
      set_config(8'd0, 8'h80, 8'd0, 1'b0);
      send_pixel(make_pixel(8'd0, 8'd100, 8'd255, 1'b0));
      set_config(8'd255, 8'd127, 8'd255, 1'b0);
      send_pixel(make_pixel(8'd0, 8'd1, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd40, 8'd90, 8'd200, 1'b1));
      set_config(8'd150, 8'h9C, 8'd200, 1'b0);
      send_pixel(make_pixel(8'd0, 8'd10, 8'd250, 1'b0));
      send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 1'b0));
   endtask

   // value-only mode, including a black pixel and mask pass-through
   task automatic test_luma_mode();
      set_config(8'd120, 8'd20, 8'd50, 1'b1);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd10, 8'd200, 8'd100, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd1, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd33, 8'd66, 8'd99, 1'b1));
      set_config(8'd0, 8'd127, 8'd0, 1'b1);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd5, 8'd3, 8'd1, 1'b0));
      set_config(8'd255, 8'h80, 8'd255, 1'b1);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd128, 8'd2, 1'b0));
   endtask

   // random pixels over a series of random settings
   task automatic test_random_settings(input int phases, input int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         set_config(8'($urandom_range(0, 255)), 8'($urandom),
                    8'($urandom_range(0, 255)), 1'($urandom));
         for (int i = 0; i < per_phase; i++) send_pixel(random_pixel());
      end
   endtask

   // output held off long enough for the pipeline to fill and stall the input
   task automatic test_backpressure();
      stall_hold = 300;
      for (int i = 0; i < 120; i++) send_pixel(random_pixel());
   endtask

   // ---------------- result checking ----------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("unexpected output pixel at %0t", $realtime);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.out_blue !== want.out_blue)
               report_mismatch("blue", rsp_data.out_blue, want.out_blue);
            if (rsp_data.out_green !== want.out_green)
               report_mismatch("green", rsp_data.out_green, want.out_green);
            if (rsp_data.out_red !== want.out_red)
               report_mismatch("red", rsp_data.out_red, want.out_red);
         end
      end
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_hold > 0) begin
            rsp_ready <= 1'b0;
            stall_hold--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_pixel_contrast_gamma_adjust_top failed");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_CONTRAST;
      csr_wdata   = '0;
      error_count = 0;
      stall_hold  = 0;
      quiet       = 1'b0;
      idle_cycles = 0;
      cur_contrast   = CONTRAST_RST;
      cur_brightness = BRIGHTNESS_RST;
      cur_gamma      = GAMMA_RST;
      cur_luma       = LUMA_MODE_RST;
      half_root[0] = sqrt_floor(64'd1 << 63);
      for (int i = 1; i < 32; i++) half_root[i] = sqrt_floor(half_root[i - 1] << 32);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_per_channel_extremes();
      test_luma_mode();
      test_random_settings(8, 50);
      test_backpressure();
      // closing stretch without idling on either side
      wait_drained();
      quiet = 1'b1;
      test_random_settings(2, 40);

      wait_drained();
      if (error_count == 0) begin
         $display("tb_pixel_contrast_gamma_adjust_top passed");
      end else begin
         $display("tb_pixel_contrast_gamma_adjust_top failed");
      end
      $finish;
   end

endmodule
